FILE: rtl/gst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gst_pkg
// Shared types and constants of the gated sine tone generator.
// ----------------------------------------------------------------------------
package gst_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 31;
    localparam int SAMPLE_BITS   = 16;
    localparam int TIMER_BITS    = 8;
    localparam int MAG_BITS      = 15;
    localparam int LEVEL_MAG_BITS = 23;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TONE_STEP   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUME      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_COEFF = 2'd2;

    localparam logic [30:0] TONE_STEP_RESET   = 31'd78741067;
    localparam logic [14:0] VOLUME_RESET      = 15'd6000;
    localparam logic [15:0] DECAY_COEFF_RESET = 16'd58982;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] HALF_Q30    = 64'd536870912;
    localparam logic [63:0] MAG_MAX     = 64'd32767;
    localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210};

    localparam logic [LEVEL_MAG_BITS-1:0] LEVEL_MAG_MAX = 23'd8388096;

    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
    } t_sine;

    // First-quadrant sine magnitude, Q2.30 Taylor series through x^15.
    function automatic logic [MAG_BITS-1:0] quarter_sine(input logic [63:0] r,
                                                         input int addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        x    = (r * HALF_PI_Q30) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        mag = (sum * 64'd32768 + HALF_Q30) >> 30;
        if (mag > MAG_MAX) begin
            mag = MAG_MAX;
        end
        return mag[MAG_BITS-1:0];
    endfunction

endpackage

FILE: rtl/gst_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gst_in_if
// Sample tick channel: valid/ready with the sound timer.
// ----------------------------------------------------------------------------
interface gst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sound_timer;

    modport source (output valid, output sound_timer, input ready);
    modport sink   (input valid, input sound_timer, output ready);
endinterface

FILE: rtl/gst_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gst_out_if
// Sample channel: valid/ready with signed left and right samples.
// ----------------------------------------------------------------------------
interface gst_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

FILE: rtl/gst_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gst_sine_rom
// Quarter-wave sine ROM with quadrant mirroring and a registered read.
// ----------------------------------------------------------------------------
module gst_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ADDR_BITS-1:0] i_idx,
    output gst_pkg::t_sine       o_sine
);
    import gst_pkg::*;

    localparam int QUARTER = 1 << (ADDR_BITS - 2);
    localparam logic [ADDR_BITS-2:0] QUARTER_A = (ADDR_BITS-1)'(QUARTER);

    typedef logic [MAG_BITS-1:0] t_rom [0:QUARTER];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i <= QUARTER; i++) begin
            rom[i] = quarter_sine(64'(i), ADDR_BITS);
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [1:0]           quad;
    logic [ADDR_BITS-2:0] offs;
    logic [ADDR_BITS-2:0] addr;
    t_sine                r_sine;

    assign quad = i_idx[ADDR_BITS-1 -: 2];
    assign offs = {1'b0, i_idx[ADDR_BITS-3:0]};
    assign addr = quad[0] ? QUARTER_A - offs : offs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine.mag <= ROM[addr];
            r_sine.neg <= quad[1];
        end
    end

    assign o_sine = r_sine;

endmodule

FILE: rtl/gated_sine_tone_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_sine_tone_generator
// DDS sine oscillator gated by a sound timer, with geometric release.
// ----------------------------------------------------------------------------
// Usage:
//   i_tick carries one transfer per audio sample with the sound timer.
//   o_sample returns one transfer per tick: the same signed sample on left
//   and right. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data:
//   0 tone_step, 1 volume, 2 decay_coeff; other indexes are dropped.
//   Timer nonzero: phase advances by the step, level = sine * volume.
//   Timer zero: phase returns to zero, level decays by decay_coeff.
// Timing:
//   Three stages: phase update, sine ROM read, level multiply into the
//   output register. A tick moves through the phase, ROM and output
//   registers in turn; sample valid rises as it enters the last. One tick
//   is taken per cycle while no held sample stalls the pipeline. The level
//   loop (one 23x16 multiply) and the phase add are each combinational.
// Reset:
//   Synchronous, active low. Phase and level go to zero, registers go to
//   880 Hz at 48 kHz, volume 6000, decay 0.9. The pipeline empties.
// Stall:
//   A held sample stalls the pipeline only once every stage is full; empty
//   stages keep taking ticks meanwhile.
// ----------------------------------------------------------------------------
module gated_sine_tone_generator #(
    parameter int SINE_TABLE_ADDR_BITS = 10,
    parameter int PHASE_BITS           = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gst_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [gst_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    gst_in_if.sink                              i_tick,
    gst_out_if.source                           o_sample
);
    import gst_pkg::*;

    localparam int A = SINE_TABLE_ADDR_BITS;

    // configuration
    logic [30:0] r_tone_step;
    logic [14:0] r_volume;
    logic [15:0] r_decay_coeff;

    // state and pipeline
    logic [PHASE_BITS-1:0]     r_phase;
    logic [PHASE_BITS-1:0]     n_phase;
    logic [31:0]               step_full;
    logic [PHASE_BITS-1:0]     step;
    logic                      r_s0_valid;
    logic                      r_s0_on;
    logic [A-1:0]              r_s0_idx;
    logic                      r_s1_valid;
    logic                      r_s1_on;
    t_sine                     s1_sine;
    logic [LEVEL_MAG_BITS-1:0] r_level_mag;
    logic [LEVEL_MAG_BITS-1:0] n_level_mag;
    logic                      r_level_neg;
    logic                      n_level_neg;
    logic                      r_out_valid;
    logic signed [15:0]        r_sample;
    logic signed [15:0]        n_sample;

    logic [LEVEL_MAG_BITS-1:0] mul_a;
    logic [15:0]               mul_b;
    logic [38:0]               prod;
    logic [MAG_BITS-1:0]       smp_mag;

    logic s2_free, s1_move, s1_free, s0_move, s0_free, in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_step   <= TONE_STEP_RESET;
            r_volume      <= VOLUME_RESET;
            r_decay_coeff <= DECAY_COEFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TONE_STEP:   r_tone_step   <= i_cfg_data[30:0];
                CFG_VOLUME:      r_volume      <= i_cfg_data[14:0];
                CFG_DECAY_COEFF: r_decay_coeff <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign s2_free = !r_out_valid || o_sample.ready;
    assign s1_move = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s1_move;
    assign s0_move = r_s0_valid && s1_free;
    assign s0_free = !r_s0_valid || s0_move;
    assign i_tick.ready = s0_free;
    assign in_xfer = i_tick.valid && s0_free;

    // stage 0: phase
    assign step_full = {1'b0, r_tone_step} >> (32 - PHASE_BITS);
    assign step      = step_full[PHASE_BITS-1:0];
    assign n_phase   = (i_tick.sound_timer != 8'd0) ? r_phase + step : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_s0_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase <= n_phase;
            end
            if (in_xfer) begin
                r_s0_valid <= 1'b1;
            end else if (s0_move) begin
                r_s0_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s0_on  <= (i_tick.sound_timer != 8'd0);
            r_s0_idx <= n_phase[PHASE_BITS-1 -: A];
        end
    end

    // stage 1: sine lookup
    gst_sine_rom #(
        .ADDR_BITS (A)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (s0_move),
        .i_idx  (r_s0_idx),
        .o_sine (s1_sine)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s0_move) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_move) begin
            r_s1_on <= r_s0_on;
        end
    end

    // stage 2: level, shared multiplier
    assign mul_a = r_s1_on ? {8'd0, s1_sine.mag} : r_level_mag;
    assign mul_b = r_s1_on ? {1'b0, r_volume} : r_decay_coeff;
    assign prod  = 39'(mul_a) * 39'(mul_b);

    assign n_level_mag = r_s1_on ? prod[29:7] : prod[38:16];
    assign n_level_neg = r_s1_on ? s1_sine.neg : r_level_neg;
    assign smp_mag     = n_level_mag[LEVEL_MAG_BITS-1:8];
    assign n_sample    = n_level_neg ? -$signed({1'b0, smp_mag}) : $signed({1'b0, smp_mag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_mag <= '0;
            r_level_neg <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_level_mag <= n_level_mag;
                r_level_neg <= n_level_neg;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_sample.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample.valid        = r_out_valid;
    assign o_sample.left_sample  = r_sample;
    assign o_sample.right_sample = r_sample;

    // checks
    a_phase_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_tick.sound_timer == 8'd0) |=> (r_phase == '0))
        else $error("phase not cleared on timer zero");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level_mag <= LEVEL_MAG_MAX)
        else $error("level magnitude out of range");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_tick.ready)
        else $error("tick stalled with output stage empty");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("stage 1 transfer lost");

    a_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_sample.ready && !s1_move) |=> !r_out_valid)
        else $error("sample repeated after transfer");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gated sine tone generator. It drives sound
// timer ticks and register writes with random idle and stall cycles. It
// predicts every sample from a bit-exact DDS model (Taylor sine table, Q16.8
// level, truncating scale toward zero) and checks both channels in order.
// ----------------------------------------------------------------------------
module tb;
    import gst_pkg::*;

    localparam int                      SINE_ADDR_BITS = 10;
    localparam int                      QUARTER        = 1 << (SINE_ADDR_BITS - 2);
    localparam int                      WATCHDOG_LIMIT = 2000;
    localparam int                      SETTLE_CYCLES  = 6;
    localparam int                      RANDOM_TICKS   = 2000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED     = 2'd3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    gst_in_if  tick_if ();
    gst_out_if sample_if ();

    gated_sine_tone_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (tick_if),
        .o_sample   (sample_if)
    );

    // model copy of registers and oscillator state
    logic [30:0]        step_reg;
    logic [14:0]        volume_reg;
    logic [15:0]        decay_reg;
    logic [31:0]        phase_acc;
    int                 level_q8;

    logic signed [15:0] sample_q[$];
    logic signed [15:0] want;
    int                 n_errors     = 0;
    int                 stall_cycles = 0;
    logic               quiet        = 1'b0;

    always #6 i_clk = ~i_clk;

    // first-quadrant sine magnitude scaled to 32768, Taylor series in Q2.30
    function automatic longint unsigned sine_quarter_mag(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned div;
        longint unsigned mag;
        x    = (r * HALF_PI_Q30) >> (SINE_ADDR_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 7; k++) begin
            div  = 64'(2 * k * (2 * k + 1));
            term = ((term * x2) >> 30) / div;
            if (k % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        mag = (acc * 64'd32768 + (64'd1 << 29)) >> 30;
        return (mag > 64'd32767) ? 64'd32767 : mag;
    endfunction

    function automatic int sine_point(input logic [SINE_ADDR_BITS-1:0] idx);
        logic [1:0]      quad;
        longint unsigned r;
        int              mag;
        quad = idx[SINE_ADDR_BITS-1 -: 2];
        r    = 64'(idx[SINE_ADDR_BITS-3:0]);
        if (quad[0]) begin
            r = 64'(QUARTER) - r;
        end
        mag = int'(sine_quarter_mag(r));
        return quad[1] ? -mag : mag;
    endfunction

    function automatic int scale_toward_zero(input int v, input longint unsigned f,
                                             input int sh);
        longint unsigned mag;
        longint          res;
        mag = (v < 0) ? longint'(-longint'(v)) : longint'(v);
        res = longint'((mag * f) >> sh);
        return (v < 0) ? int'(-res) : int'(res);
    endfunction

    function automatic logic signed [15:0] next_sample(input logic [7:0] timer);
        if (timer != 8'd0) begin
            phase_acc = phase_acc + {1'b0, step_reg};
            level_q8  = scale_toward_zero(sine_point(phase_acc[31 -: SINE_ADDR_BITS]),
                                          64'(volume_reg), 7);
        end else begin
            phase_acc = '0;
            level_q8  = scale_toward_zero(level_q8, 64'(decay_reg), 16);
        end
        return 16'(scale_toward_zero(level_q8, 64'd1, 8));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TONE_STEP:   step_reg   = data[30:0];
            CFG_VOLUME:      volume_reg = data[14:0];
            CFG_DECAY_COEFF: decay_reg  = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_tick(input logic [7:0] timer);
        if (!quiet && $urandom_range(99) < 11) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid       <= 1'b1;
        tick_if.sound_timer <= timer;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        sample_q.push_back(next_sample(timer));
    endtask

    task automatic wait_idle();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (sample_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        send_tick(8'hFF);
        send_tick(8'h01);
        send_tick(8'h80);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_TONE_STEP, 31'h7FFF_FFFF);
        write_reg(CFG_VOLUME, 31'd32767);
        write_reg(CFG_DECAY_COEFF, 31'd65535);
        send_tick(8'h80);
        send_tick(8'h01);
        send_tick(8'hFE);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();
        // move the phase off zero, then hold it with a zero step
        write_reg(CFG_TONE_STEP, 31'h1234_5678);
        send_tick(8'h7F);
        send_tick(8'h7F);
        wait_idle();
        write_reg(CFG_TONE_STEP, 31'd0);
        write_reg(CFG_DECAY_COEFF, 31'd0);
        send_tick(8'h7F);
        send_tick(8'h7F);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();
        write_reg(CFG_TONE_STEP, 31'd78741067);
        write_reg(CFG_VOLUME, 31'd0);
        send_tick(8'h55);
        send_tick(8'hAA);
        wait_idle();
    endtask

    task automatic test_register_writes();
        write_reg(CFG_VOLUME, 31'h7FFF_0000 | 31'd12345);
        write_reg(CFG_DECAY_COEFF, 31'h7FFF_0000 | 31'd40000);
        write_reg(CFG_UNUSED, 31'h7FFF_FFFF);
        send_tick(8'h33);
        send_tick(8'hCC);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();
    endtask

    task automatic pick_registers();
        logic [30:0] step;
        logic [14:0] vol;
        logic [15:0] dec;
        case ($urandom_range(3))
            0:       step = '0;
            1:       step = '1;
            2:       step = 31'($urandom_range(1, 200000000));
            default: step = 31'($urandom);
        endcase
        case ($urandom_range(3))
            0:       vol = '0;
            1:       vol = '1;
            default: vol = 15'($urandom);
        endcase
        case ($urandom_range(4))
            0:       dec = '0;
            1:       dec = '1;
            2:       dec = 16'($urandom);
            default: dec = 16'($urandom_range(50000, 65535));
        endcase
        write_reg(CFG_TONE_STEP, step);
        write_reg(CFG_VOLUME, {16'($urandom), vol});
        write_reg(CFG_DECAY_COEFF, {15'($urandom), dec});
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_UNUSED, 31'($urandom));
        end
    endtask

    // tone bursts followed by release tails, with some segments of raw noise
    task automatic test_random_bursts();
        int sent;
        int n;
        int batch;
        int on_len;
        int off_len;
        sent  = 0;
        batch = 0;
        while (sent < RANDOM_TICKS) begin
            wait_idle();
            if (batch % 4 != 1) begin
                pick_registers();
            end
            quiet = (batch == 2);
            n = 0;
            while (n < 150) begin
                on_len  = $urandom_range(1, 40);
                off_len = $urandom_range(1, 60);
                if ($urandom_range(4) == 0) begin
                    repeat (on_len + off_len) send_tick(8'($urandom_range(255)));
                end else begin
                    repeat (on_len) send_tick(8'($urandom_range(1, 255)));
                    repeat (off_len) send_tick(8'd0);
                end
                n += on_len + off_len;
            end
            quiet = 1'b0;
            sent += n;
            batch++;
        end
    endtask

    initial begin
        sample_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            sample_if.ready <= quiet || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && sample_if.valid === 1'b1 && sample_if.ready === 1'b1) begin
            if (sample_q.size() == 0) begin
                $error("sample transfer with nothing expected: left_sample %0d",
                       sample_if.left_sample);
                n_errors++;
            end else begin
                want = sample_q.pop_front();
                if (sample_if.left_sample !== want) begin
                    $error("left_sample: expected %0d, got %0d", want, sample_if.left_sample);
                    n_errors++;
                end
                if (sample_if.right_sample !== want) begin
                    $error("right_sample: expected %0d, got %0d", want,
                           sample_if.right_sample);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (tick_if.valid === 1'b1 && tick_if.ready === 1'b1)
                || (sample_if.valid === 1'b1 && sample_if.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_TONE_STEP;
        i_cfg_data          <= '0;
        tick_if.valid       <= 1'b0;
        tick_if.sound_timer <= '0;
        step_reg   = TONE_STEP_RESET;
        volume_reg = VOLUME_RESET;
        decay_reg  = DECAY_COEFF_RESET;
        phase_acc  = '0;
        level_q8   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_extremes();
        test_register_writes();
        test_random_bursts();
        wait_idle();

        if (n_errors == 0 && sample_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gst_pkg.sv
rtl/gst_in_if.sv
rtl/gst_out_if.sv
rtl/gst_sine_rom.sv
rtl/gated_sine_tone_generator.sv
bench/tb.sv
